FILE: design/bir_pkg.sv
package bir_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_SRC_DIM   = 256;
   localparam int DEF_MAX_DST_DIM   = 256;
   localparam int DEF_FRACTION_BITS = 10;

   // fixed field widths
   localparam int DIM_REG_W   = 9;
   localparam int STEP_W      = 16;
   localparam int POS_W       = 8;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 3;
   localparam int PIXEL_W     = NUM_CHAN * CHAN_W;
   localparam int PROD_W      = POS_W + STEP_W;
   localparam int REQ_TDATA_W = 2 * POS_W + PIXEL_W;
   localparam int RSP_TDATA_W = 2 * POS_W + PIXEL_W;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;

   typedef enum logic {
      KIND_STORE   = 1'b0,
      KIND_COMPUTE = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MUL,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RD01,
      BK_RD10,
      BK_RD11,
      BK_BOT,
      BK_VERT
   } back_state_type;

   // scale steps and whether they are being recomputed
   typedef struct packed {
      logic              busy;
      logic [STEP_W-1:0] h_step;
      logic [STEP_W-1:0] v_step;
   } step_info_type;

endpackage

FILE: design/bilinear_image_resize_top.sv
// Bilinear image resizer. Load the source frame first with store beats
// (tuser 0, one pixel each, to column pos_x and row pos_y), then send compute
// beats (tuser 1) with a destination column and row; each compute beat gives
// one result beat with the interpolated three channel pixel, in request order.
// Stores outside the frame store are dropped and give no result. In the back end
// a compute makes four reads of the single port frame store, in the idle and
// RD01, RD10 and RD11 states, and blends in RD10, BOT and VERT; the back end
// takes no new queue entry until it is through with the last. A store beat
// passes the front end through its idle and push states and is written in the
// back end's idle state. After reset and after every register write the input
// stalls while a shared serial divider works out the two scale steps.
module bilinear_image_resize_top #(
   parameter int MAX_SRC_DIM   = bir_pkg::DEF_MAX_SRC_DIM,
   parameter int MAX_DST_DIM   = bir_pkg::DEF_MAX_DST_DIM,
   parameter int FRACTION_BITS = bir_pkg::DEF_FRACTION_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x, pos_y, in_chan0, in_chan1, in_chan2
   input  logic [bir_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_chan0, out_chan1, out_chan2
   output logic [bir_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bir_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bir_pkg::DIM_REG_W-1:0]     csr_data
);
   import bir_pkg::*;

   localparam int CW = $clog2(MAX_SRC_DIM);
   localparam int EW = 1 + 2*POS_W + 4*CW + 2*FRACTION_BITS + PIXEL_W;

   step_info_type  step_info;
   logic [CW-1:0]  last_x, last_y;
   logic           push_valid, push_ready;
   logic [EW-1:0]  push_data;
   logic           pop_valid, pop_ready;
   logic [EW-1:0]  pop_data;

   bir_cfg #(
      .MAX_SRC_DIM   (MAX_SRC_DIM),
      .MAX_DST_DIM   (MAX_DST_DIM),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step_info (step_info),
      .last_x    (last_x),
      .last_y    (last_y)
   );

   bir_front #(
      .MAX_SRC_DIM   (MAX_SRC_DIM),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .step_info  (step_info),
      .last_x     (last_x),
      .last_y     (last_y),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   bir_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bir_back #(
      .MAX_SRC_DIM   (MAX_SRC_DIM),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: design/bir_cfg.sv
module bir_cfg #(
   parameter int MAX_SRC_DIM   = bir_pkg::DEF_MAX_SRC_DIM,
   parameter int MAX_DST_DIM   = bir_pkg::DEF_MAX_DST_DIM,
   parameter int FRACTION_BITS = bir_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bir_pkg::DIM_REG_W-1:0]       csr_data,
   output bir_pkg::step_info_type              step_info,
   output logic [$clog2(MAX_SRC_DIM)-1:0]      last_x,
   output logic [$clog2(MAX_SRC_DIM)-1:0]      last_y
);
   import bir_pkg::*;

   localparam int SW   = $clog2(MAX_SRC_DIM + 1);
   localparam int DW   = $clog2(MAX_DST_DIM + 1);
   localparam int CW   = $clog2(MAX_SRC_DIM);
   localparam int NB   = SW + FRACTION_BITS;
   localparam int CNTW = $clog2(NB + 1);

   logic [DIM_REG_W-1:0] src_width_ff, src_width_in;
   logic [DIM_REG_W-1:0] src_height_ff, src_height_in;
   logic [DIM_REG_W-1:0] dst_width_ff, dst_width_in;
   logic [DIM_REG_W-1:0] dst_height_ff, dst_height_in;
   logic                 start_ff, start_in;
   logic                 run_ff, run_in;
   logic                 phase_ff, phase_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [NB-1:0]        quo_ff, quo_in;
   logic [DW-1:0]        den_ff, den_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [STEP_W-1:0]    h_step_ff, h_step_in;
   logic [STEP_W-1:0]    v_step_ff, v_step_in;

   logic [SW-1:0] src_w_c, src_h_c;
   logic [DW-1:0] dst_w_c, dst_h_c;
   logic [DW:0]   div_shift;
   logic [DW:0]   div_diff;
   logic          div_ge;
   logic [NB-1:0] div_quo;
   logic          csr_write;

   function automatic logic [SW-1:0] clamp_src(input logic [DIM_REG_W-1:0] v);
      if (v == '0) return SW'(1);
      if (32'(v) > 32'(MAX_SRC_DIM)) return SW'(MAX_SRC_DIM);
      return SW'(v);
   endfunction

   function automatic logic [DW-1:0] clamp_dst(input logic [DIM_REG_W-1:0] v);
      if (v == '0) return DW'(1);
      if (32'(v) > 32'(MAX_DST_DIM)) return DW'(MAX_DST_DIM);
      return DW'(v);
   endfunction

   assign src_w_c = clamp_src(src_width_ff);
   assign src_h_c = clamp_src(src_height_ff);
   assign dst_w_c = clamp_dst(dst_width_ff);
   assign dst_h_c = clamp_dst(dst_height_ff);

   assign last_x = CW'(src_w_c - SW'(1));
   assign last_y = CW'(src_h_c - SW'(1));

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   assign step_info.busy   = start_ff | run_ff;
   assign step_info.h_step = h_step_ff;
   assign step_info.v_step = v_step_ff;

   // one restoring division step per cycle
   assign div_shift = {rem_ff, quo_ff[NB-1]};
   assign div_diff  = div_shift - {1'b0, den_ff};
   assign div_ge    = (div_shift >= {1'b0, den_ff});
   assign div_quo   = {quo_ff[NB-2:0], div_ge};

   // register writes and step recomputation, width step first then height step
   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      start_in      = start_ff;
      run_in        = run_ff;
      phase_in      = phase_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      cnt_in        = cnt_ff;
      h_step_in     = h_step_ff;
      v_step_in     = v_step_ff;

      if (start_ff) begin
         start_in = 1'b0;
         run_in   = 1'b1;
         phase_in = 1'b0;
         rem_in   = '0;
         quo_in   = {src_w_c, {FRACTION_BITS{1'b0}}};
         den_in   = dst_w_c;
         cnt_in   = CNTW'(NB);
      end else if (run_ff) begin
         rem_in = div_ge ? div_diff[DW-1:0] : div_shift[DW-1:0];
         quo_in = div_quo;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            if (!phase_ff) begin
               h_step_in = STEP_W'(div_quo);
               phase_in  = 1'b1;
               rem_in    = '0;
               quo_in    = {src_h_c, {FRACTION_BITS{1'b0}}};
               den_in    = dst_h_c;
               cnt_in    = CNTW'(NB);
            end else begin
               v_step_in = STEP_W'(div_quo);
               run_in    = 1'b0;
            end
         end
      end

      if (csr_write) begin
         start_in = 1'b1;
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_in  = csr_data;
            CSR_SRC_HEIGHT: src_height_in = csr_data;
            CSR_DST_WIDTH:  dst_width_in  = csr_data;
            CSR_DST_HEIGHT: dst_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_RESET;
         src_height_ff <= DIM_RESET;
         dst_width_ff  <= DIM_RESET;
         dst_height_ff <= DIM_RESET;
         start_ff      <= 1'b1;
         run_ff        <= 1'b0;
         phase_ff      <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
         start_ff      <= start_in;
         run_ff        <= run_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
      end
   end

   // datapath of the divider
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      h_step_ff <= h_step_in;
      v_step_ff <= v_step_in;
   end

endmodule

FILE: design/bir_front.sv
module bir_front #(
   parameter int MAX_SRC_DIM   = bir_pkg::DEF_MAX_SRC_DIM,
   parameter int FRACTION_BITS = bir_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bir_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [0:0]                          req_tuser,
   input  bir_pkg::step_info_type              step_info,
   input  logic [$clog2(MAX_SRC_DIM)-1:0]      last_x,
   input  logic [$clog2(MAX_SRC_DIM)-1:0]      last_y,
   output logic                                push_valid,
   input  logic                                push_ready,
   output logic [1 + 2*bir_pkg::POS_W + 4*$clog2(MAX_SRC_DIM) + 2*FRACTION_BITS
                 + bir_pkg::PIXEL_W - 1:0]      push_data
);
   import bir_pkg::*;

   localparam int CW = $clog2(MAX_SRC_DIM);
   localparam int F  = FRACTION_BITS;

   front_state_type      state_ff, state_in;
   req_kind_type         kind_ff;
   logic [POS_W-1:0]     px_ff, py_ff;
   logic [PIXEL_W-1:0]   pix_ff;
   logic [PROD_W-1:0]    tx_ff, ty_ff;

   logic                 accept;
   logic                 in_range;
   logic                 capture;
   logic [CW-1:0]        x0, x1, y0, y1;
   logic [F-1:0]         fx, fy;

   // integer neighbours and fraction along one axis, clamped at the last one
   function automatic void map_axis(input  logic [PROD_W-1:0] t,
                                    input  logic [CW-1:0]     last,
                                    output logic [CW-1:0]     c0,
                                    output logic [CW-1:0]     c1,
                                    output logic [F-1:0]      fr);
      logic [PROD_W-1:0] c;
      c = t >> F;
      if (c < PROD_W'(last)) begin
         c0 = CW'(c);
         c1 = CW'(c) + CW'(1);
         fr = t[F-1:0];
      end else begin
         c0 = last;
         c1 = last;
         fr = '0;
      end
   endfunction

   assign req_tready = (state_ff == FR_IDLE) && !step_info.busy;
   assign accept     = req_tvalid & req_tready;
   assign in_range   = (32'(req_tdata[POS_W-1:0]) < 32'(MAX_SRC_DIM)) &&
                       (32'(req_tdata[2*POS_W-1:POS_W]) < 32'(MAX_SRC_DIM));

   // sequencer: compute beats pass the multiply state, in-range stores go straight to push
   always_comb begin
      state_in   = state_ff;
      push_valid = 1'b0;
      capture    = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               capture = 1'b1;
               if (req_kind_type'(req_tuser[0]) == KIND_COMPUTE) begin
                  state_in = FR_MUL;
               end else if (in_range) begin
                  state_in = FR_PUSH;
               end
            end
         end
         FR_MUL: begin
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // beat capture and source position products
   always_ff @(posedge clock) begin
      if (capture) begin
         kind_ff <= req_kind_type'(req_tuser[0]);
         px_ff   <= req_tdata[POS_W-1:0];
         py_ff   <= req_tdata[2*POS_W-1:POS_W];
         pix_ff  <= req_tdata[REQ_TDATA_W-1:2*POS_W];
      end
      if (state_ff == FR_MUL) begin
         tx_ff <= PROD_W'(px_ff) * PROD_W'(step_info.h_step);
         ty_ff <= PROD_W'(py_ff) * PROD_W'(step_info.v_step);
      end
   end

   // queue entry; a store carries its target in x0 and y0
   always_comb begin
      map_axis(tx_ff, last_x, x0, x1, fx);
      map_axis(ty_ff, last_y, y0, y1, fy);
      if (kind_ff == KIND_STORE) begin
         x0 = CW'(px_ff);
         y0 = CW'(py_ff);
         x1 = '0;
         y1 = '0;
         fx = '0;
         fy = '0;
      end
      push_data = {kind_ff, px_ff, py_ff, x0, x1, y0, y1, fx, fy, pix_ff};
   end

endmodule

FILE: design/bir_queue.sv
module bir_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bir_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + NW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/bir_back.sv
module bir_back #(
   parameter int MAX_SRC_DIM   = bir_pkg::DEF_MAX_SRC_DIM,
   parameter int FRACTION_BITS = bir_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  logic [1 + 2*bir_pkg::POS_W + 4*$clog2(MAX_SRC_DIM) + 2*FRACTION_BITS
                 + bir_pkg::PIXEL_W - 1:0]      pop_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bir_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import bir_pkg::*;

   localparam int CW        = $clog2(MAX_SRC_DIM);
   localparam int F         = FRACTION_BITS;
   localparam int MEM_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int LW        = F + CHAN_W + 2;

   back_state_type      state_ff, state_in;

   // head of the queue
   logic                hd_kind;
   logic [POS_W-1:0]    hd_px, hd_py;
   logic [CW-1:0]       hd_x0, hd_x1, hd_y0, hd_y1;
   logic [F-1:0]        hd_fx, hd_fy;
   logic [PIXEL_W-1:0]  hd_pix;

   // job in progress
   logic [POS_W-1:0]    px_ff, py_ff;
   logic [CW-1:0]       x0_ff, x1_ff, y0_ff, y1_ff;
   logic [F-1:0]        fx_ff, fy_ff;

   logic [PIXEL_W-1:0]  mem [MEM_DEPTH];
   logic [PIXEL_W-1:0]  rd_data_ff;
   logic [PIXEL_W-1:0]  left_ff;
   logic [PIXEL_W-1:0]  top_ff, bot_ff;
   logic                rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic                mem_we;
   logic                rsp_load;
   logic [CW-1:0]       ax, ay;
   logic [AW-1:0]       addr;
   logic [PIXEL_W-1:0]  lerp_a, lerp_b, lerp_r;
   logic [F-1:0]        lerp_f;

   // a + floor(f * (b - a) / 2^F)
   function automatic logic [CHAN_W-1:0] lerp(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b,
                                              input logic [F-1:0]      f);
      logic signed [F:0]      fs;
      logic signed [CHAN_W:0] d;
      logic signed [LW-1:0]   p;
      logic signed [LW-1:0]   s;
      fs = $signed({1'b0, f});
      d  = $signed({1'b0, b}) - $signed({1'b0, a});
      p  = fs * d;
      s  = (p >>> F) + $signed(LW'(a));
      return s[CHAN_W-1:0];
   endfunction

   assign {hd_kind, hd_px, hd_py, hd_x0, hd_x1, hd_y0, hd_y1, hd_fx, hd_fy, hd_pix} =
      pop_data;

   // sequencer: stores write; computes do four reads, two row blends, a column blend
   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      ax        = x0_ff;
      ay        = y0_ff;
      case (state_ff)
         BK_IDLE: begin
            ax = hd_x0;
            ay = hd_y0;
            if (pop_valid) begin
               pop_ready = 1'b1;
               if (hd_kind == KIND_STORE) begin
                  mem_we = 1'b1;
               end else begin
                  state_in = BK_RD01;
               end
            end
         end
         BK_RD01: begin
            ax       = x1_ff;
            state_in = BK_RD10;
         end
         BK_RD10: begin
            ay       = y1_ff;
            state_in = BK_RD11;
         end
         BK_RD11: begin
            ax       = x1_ff;
            ay       = y1_ff;
            state_in = BK_BOT;
         end
         BK_BOT: begin
            state_in = BK_VERT;
         end
         BK_VERT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign addr = AW'(ay) * AW'(MAX_SRC_DIM) + AW'(ax);

   // shared blend units, one per channel
   always_comb begin
      if (state_ff == BK_VERT) begin
         lerp_a = top_ff;
         lerp_b = bot_ff;
         lerp_f = fy_ff;
      end else begin
         lerp_a = left_ff;
         lerp_b = rd_data_ff;
         lerp_f = fx_ff;
      end
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         lerp_r[ch*CHAN_W +: CHAN_W] = lerp(lerp_a[ch*CHAN_W +: CHAN_W],
                                            lerp_b[ch*CHAN_W +: CHAN_W], lerp_f);
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= hd_pix;
      end
      rd_data_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // job fields, left neighbours and row blends
   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && pop_valid) begin
         px_ff <= hd_px;
         py_ff <= hd_py;
         x0_ff <= hd_x0;
         x1_ff <= hd_x1;
         y0_ff <= hd_y0;
         y1_ff <= hd_y1;
         fx_ff <= hd_fx;
         fy_ff <= hd_fy;
      end
      if (state_ff == BK_RD01 || state_ff == BK_RD11) begin
         left_ff <= rd_data_ff;
      end
      if (state_ff == BK_RD10) begin
         top_ff <= lerp_r;
      end
      if (state_ff == BK_BOT) begin
         bot_ff <= lerp_r;
      end
      if (rsp_load) begin
         rsp_data_ff <= {lerp_r, py_ff, px_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: sim/bilinear_image_resize_top_test.sv
module bilinear_image_resize_top_test;
   import bir_pkg::*;

   localparam int FRAC      = DEF_FRACTION_BITS;
   localparam int FRAC_MASK = (1 << FRAC) - 1;
   localparam int SRC_MAX   = DEF_MAX_SRC_DIM;
   localparam int DST_MAX   = DEF_MAX_DST_DIM;
   localparam int SETTLE    = 16;     // front end plus back end, with margin
   localparam int WATCHDOG  = 2000;   // cycles without any beat
   localparam int PHASES    = 12;

   // one pixel beat, same layout on tdata of both channels
   typedef struct packed {
      logic [CHAN_W-1:0] chan2;
      logic [CHAN_W-1:0] chan1;
      logic [CHAN_W-1:0] chan0;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  x;
   } pixel_beat_type;

   typedef enum logic [1:0] {
      ROW_STORE,
      ROW_COMPUTE,
      ROW_CSR
   } plan_op_type;

   typedef struct packed {
      plan_op_type          op;
      logic [DIM_REG_W-1:0] a;       // column, or register index
      logic [DIM_REG_W-1:0] b;       // row, or register value
      logic                 typed;   // pix holds the expected pixel
      logic [PIXEL_W-1:0]   pix;
   } plan_row_type;

   localparam int PLAN_LEN = 31;
   localparam plan_row_type PLAN [PLAN_LEN] = '{
      // corners and a 2x2 block, channel extremes
      '{ROW_STORE, 9'd0, 9'd0, 1'b0, 24'h000000},
      '{ROW_STORE, 9'd1, 9'd0, 1'b0, 24'hFFFFFF},
      '{ROW_STORE, 9'd0, 9'd1, 1'b0, 24'h0FAA55},
      '{ROW_STORE, 9'd1, 9'd1, 1'b0, 24'hF05AA5},
      '{ROW_STORE, 9'd255, 9'd255, 1'b0, 24'h8000FF},
      '{ROW_STORE, 9'd255, 9'd0, 1'b0, 24'h563412},
      '{ROW_STORE, 9'd255, 9'd1, 1'b0, 24'h01FE7F},
      '{ROW_STORE, 9'd0, 9'd255, 1'b0, 24'hC33C99},
      '{ROW_STORE, 9'd1, 9'd255, 1'b0, 24'h000000},
      // reset scale: every destination pixel sits on its own source pixel
      '{ROW_COMPUTE, 9'd0, 9'd0, 1'b1, 24'h000000},
      '{ROW_COMPUTE, 9'd255, 9'd255, 1'b1, 24'h8000FF},
      '{ROW_COMPUTE, 9'd255, 9'd0, 1'b1, 24'h563412},
      '{ROW_COMPUTE, 9'd0, 9'd255, 1'b1, 24'hC33C99},
      // 2x2 up to 4x4: half fractions, rising and falling differences
      '{ROW_CSR, 9'(CSR_SRC_WIDTH), 9'd2, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_SRC_HEIGHT), 9'd2, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_DST_WIDTH), 9'd4, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_DST_HEIGHT), 9'd4, 1'b0, 24'h0},
      '{ROW_COMPUTE, 9'd1, 9'd1, 1'b0, 24'h0},
      '{ROW_COMPUTE, 9'd1, 9'd2, 1'b0, 24'h0},
      '{ROW_COMPUTE, 9'd3, 9'd3, 1'b1, 24'hF05AA5},
      '{ROW_COMPUTE, 9'd255, 9'd255, 1'b1, 24'hF05AA5},
      // zero and oversize registers clamp
      '{ROW_CSR, 9'(CSR_SRC_WIDTH), 9'd0, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_DST_WIDTH), 9'd511, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_DST_HEIGHT), 9'd0, 1'b0, 24'h0},
      '{ROW_COMPUTE, 9'd200, 9'd0, 1'b1, 24'h000000},
      '{ROW_COMPUTE, 9'd200, 9'd1, 1'b1, 24'h0FAA55},
      // full source onto one pixel: the step wraps to zero in 16 bits
      '{ROW_CSR, 9'(CSR_SRC_WIDTH), 9'd511, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_SRC_HEIGHT), 9'd256, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_DST_WIDTH), 9'd1, 1'b0, 24'h0},
      '{ROW_CSR, 9'(CSR_DST_HEIGHT), 9'd1, 1'b0, 24'h0},
      '{ROW_COMPUTE, 9'd255, 9'd255, 1'b1, 24'h000000}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = KIND_STORE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SRC_WIDTH;
   logic [DIM_REG_W-1:0]   csr_data = '0;

   // resizer mirror: registers, steps and frame store
   logic [DIM_REG_W-1:0] dim_reg [4];
   logic [STEP_W-1:0]    h_step;
   logic [STEP_W-1:0]    v_step;
   logic [PIXEL_W-1:0]   frame_px [SRC_MAX*SRC_MAX];
   bit                   px_loaded [SRC_MAX*SRC_MAX];

   pixel_beat_type pending_px [$];
   int             fail_count = 0;
   int             quiet_cycles = 0;
   int             req_idle_pct = 0;
   int             rsp_idle_pct = 0;

   bilinear_image_resize_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic int eff_dim(logic [DIM_REG_W-1:0] v, int dim_max);
      if (v == '0) return 1;
      if (int'(v) > dim_max) return dim_max;
      return int'(v);
   endfunction

   function automatic logic [STEP_W-1:0] scale_step(logic [DIM_REG_W-1:0] src,
                                                    logic [DIM_REG_W-1:0] dst);
      int quotient;
      quotient = (eff_dim(src, SRC_MAX) << FRAC) / eff_dim(dst, DST_MAX);
      return quotient[STEP_W-1:0];
   endfunction

   // source coordinate pair and fraction along one axis, saturating at the edge
   function automatic void map_axis(input int pos, input logic [STEP_W-1:0] step,
                                    input logic [DIM_REG_W-1:0] size,
                                    output int c0, output int c1, output int frac);
      int end_pos;
      int t;
      end_pos = eff_dim(size, SRC_MAX) - 1;
      t = pos * int'(step);
      if ((t >> FRAC) < end_pos) begin
         c0 = t >> FRAC;
         c1 = c0 + 1;
         frac = t & FRAC_MASK;
      end else begin
         c0 = end_pos;
         c1 = end_pos;
         frac = 0;
      end
   endfunction

   // a + floor(f * (b - a) / 2^FRAC)
   function automatic int blend(int a, int b, int f);
      if (b >= a) return a + ((f * (b - a)) >> FRAC);
      return a - ((f * (a - b) + FRAC_MASK) >> FRAC);
   endfunction

   function automatic pixel_beat_type resize_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
      int x0, x1, fx, y0, y1, fy, top_val, bot_val, ch;
      logic [PIXEL_W-1:0] p00, p01, p10, p11, chans;
      pixel_beat_type r;
      map_axis(int'(x), h_step, dim_reg[CSR_SRC_WIDTH], x0, x1, fx);
      map_axis(int'(y), v_step, dim_reg[CSR_SRC_HEIGHT], y0, y1, fy);
      p00 = frame_px[y0*SRC_MAX + x0];
      p01 = frame_px[y0*SRC_MAX + x1];
      p10 = frame_px[y1*SRC_MAX + x0];
      p11 = frame_px[y1*SRC_MAX + x1];
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         top_val = blend(int'(p00[ch*CHAN_W +: CHAN_W]), int'(p01[ch*CHAN_W +: CHAN_W]), fx);
         bot_val = blend(int'(p10[ch*CHAN_W +: CHAN_W]), int'(p11[ch*CHAN_W +: CHAN_W]), fx);
         chans[ch*CHAN_W +: CHAN_W] = CHAN_W'(blend(top_val, bot_val, fy));
      end
      r.x = x;
      r.y = y;
      {r.chan2, r.chan1, r.chan0} = chans;
      return r;
   endfunction

   function automatic logic [CHAN_W-1:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [PIXEL_W-1:0] rand_pixel();
      return {rand_byte(), rand_byte(), rand_byte()};
   endfunction

   function automatic logic [DIM_REG_W-1:0] pick_dst();
      case ($urandom_range(0, 3))
         0: return DIM_REG_W'($urandom_range(1, 8));
         1: begin
            case ($urandom_range(0, 3))
               0: return 9'd0;
               1: return 9'd1;
               2: return 9'd256;
               default: return 9'd511;
            endcase
         end
         default: return DIM_REG_W'($urandom_range(0, 511));
      endcase
   endfunction

   function automatic void check_field(string name, logic [CHAN_W-1:0] want,
                                       logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void set_idling(int mode);
      case (mode)
         0: begin req_idle_pct = 20; rsp_idle_pct = 88; end
         1: begin req_idle_pct = 88; rsp_idle_pct = 20; end
         default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
      endcase
   endfunction

   // one request beat; for a compute, pix is the typed-in result if typed is set
   task automatic send_beat(req_kind_type kind, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [PIXEL_W-1:0] pix, logic typed);
      pixel_beat_type beat;
      beat.x = x;
      beat.y = y;
      {beat.chan2, beat.chan1, beat.chan0} = pix;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_STORE) begin
         frame_px[int'(y)*SRC_MAX + int'(x)] = pix;
         px_loaded[int'(y)*SRC_MAX + int'(x)] = 1'b1;
      end else if (typed) begin
         pending_px.push_back(beat);
      end else begin
         pending_px.push_back(resize_pixel(x, y));
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [DIM_REG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dim_reg[idx] = value;
      h_step = scale_step(dim_reg[CSR_SRC_WIDTH], dim_reg[CSR_DST_WIDTH]);
      v_step = scale_step(dim_reg[CSR_SRC_HEIGHT], dim_reg[CSR_DST_HEIGHT]);
   endtask

   // drain results, then let trailing stores finish
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // every source pixel the current frame can touch that is not yet loaded gets written
   task automatic fill_frame();
      int r, c;
      for (r = 0; r < eff_dim(dim_reg[CSR_SRC_HEIGHT], SRC_MAX); r++)
         for (c = 0; c < eff_dim(dim_reg[CSR_SRC_WIDTH], SRC_MAX); c++)
            if (!px_loaded[r*SRC_MAX + c])
               send_beat(KIND_STORE, POS_W'(c), POS_W'(r), rand_pixel(), 1'b0);
   endtask

   task automatic random_beat();
      int w, h;
      logic [POS_W-1:0] x, y;
      if ($urandom_range(0, 99) < 55) begin
         // mostly inside the destination frame, sometimes anywhere
         w = eff_dim(dim_reg[CSR_DST_WIDTH], DST_MAX);
         h = eff_dim(dim_reg[CSR_DST_HEIGHT], DST_MAX);
         x = ($urandom_range(0, 3) != 0) ? POS_W'($urandom_range(0, w - 1))
                                         : POS_W'($urandom_range(0, 255));
         y = ($urandom_range(0, 3) != 0) ? POS_W'($urandom_range(0, h - 1))
                                         : POS_W'($urandom_range(0, 255));
         send_beat(KIND_COMPUTE, x, y, rand_pixel(), 1'b0);
      end else begin
         // rewrite inside the source frame, or store anywhere
         w = eff_dim(dim_reg[CSR_SRC_WIDTH], SRC_MAX);
         h = eff_dim(dim_reg[CSR_SRC_HEIGHT], SRC_MAX);
         if ($urandom_range(0, 1) != 0) begin
            x = POS_W'($urandom_range(0, w - 1));
            y = POS_W'($urandom_range(0, h - 1));
         end else begin
            x = POS_W'($urandom_range(0, 255));
            y = POS_W'($urandom_range(0, 255));
         end
         send_beat(KIND_STORE, x, y, rand_pixel(), 1'b0);
      end
   endtask

   // result side: random back-pressure and in-order compare
   always @(posedge clock) begin
      pixel_beat_type got;
      pixel_beat_type want;
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_px.size() == 0) begin
            $display("%0t: result beat expected none got %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_px.pop_front();
            check_field("out_x", want.x, got.x);
            check_field("out_y", want.y, got.y);
            check_field("out_chan0", want.chan0, got.chan0);
            check_field("out_chan1", want.chan1, got.chan1);
            check_field("out_chan2", want.chan2, got.chan2);
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("bilinear_image_resize_top test failed");
         $finish;
      end
   end

   initial begin
      int i, ph, r;
      logic [DIM_REG_W-1:0] cfg [4];

      for (i = 0; i < 4; i++) dim_reg[i] = DIM_RESET;
      h_step = scale_step(DIM_RESET, DIM_RESET);
      v_step = h_step;
      set_idling(0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < PLAN_LEN; i++) begin
         case (PLAN[i].op)
            ROW_CSR: begin
               if (i == 0 || PLAN[i-1].op != ROW_CSR) settle_block();
               write_reg(csr_index_type'(PLAN[i].a[CSR_INDEX_W-1:0]), PLAN[i].b);
               if (i == PLAN_LEN - 1 || PLAN[i+1].op != ROW_CSR) csr_valid <= 1'b0;
            end
            ROW_STORE: begin
               send_beat(KIND_STORE, PLAN[i].a[POS_W-1:0], PLAN[i].b[POS_W-1:0],
                         PLAN[i].pix, 1'b0);
            end
            default: begin
               send_beat(KIND_COMPUTE, PLAN[i].a[POS_W-1:0], PLAN[i].b[POS_W-1:0],
                         PLAN[i].pix, PLAN[i].typed);
            end
         endcase
      end

      // random phases; two of them stretch the source to full width or height
      for (ph = 0; ph < PHASES; ph++) begin
         set_idling(ph / 4);
         if (ph == 1) begin
            cfg[0] = 9'd256;
            cfg[1] = DIM_REG_W'($urandom_range(0, 1));
         end else if (ph == 6) begin
            cfg[0] = DIM_REG_W'($urandom_range(0, 1));
            cfg[1] = 9'd511;
         end else begin
            cfg[0] = DIM_REG_W'($urandom_range(0, 8));
            cfg[1] = DIM_REG_W'($urandom_range(0, 8));
         end
         cfg[2] = pick_dst();
         cfg[3] = pick_dst();
         settle_block();
         for (r = 0; r < 4; r++) write_reg(csr_index_type'(r), cfg[r]);
         csr_valid <= 1'b0;
         fill_frame();
         repeat ((ph == 1 || ph == 6) ? 30 : 45) random_beat();
      end

      settle_block();
      if (fail_count == 0)
         $display("bilinear_image_resize_top test passed");
      else
         $display("bilinear_image_resize_top test failed");
      $finish;
   end

endmodule
